// ===== src/dfarm_pkg.sv =====
// Shared types and constants for the range-table DFA matcher.
package dfarm_pkg;

    // Item function codes, carried in s_tuser
    typedef enum logic [1:0] {
        FUNC_WR_HDR  = 2'd0,
        FUNC_WR_SLOT = 2'd1,
        FUNC_START   = 2'd2,
        FUNC_CHAR    = 2'd3
    } func_t;

    // Fixed field widths
    localparam int CHAR_W   = 21;
    localparam int TGT_W    = 9;
    localparam int SIDX_W   = 8;
    localparam int SLOT_W   = 4;
    localparam int CNT_IN_W = 5;
    localparam int OLEN_W   = 16;
    localparam int SLOTE_W  = TGT_W + 2 * CHAR_W;

    // Configuration register byte addresses
    localparam logic [2:0] ADDR_GREEDY = 3'd0;
    localparam logic [2:0] ADDR_DEAD   = 3'd4;
    localparam logic [8:0] DEAD_RESET  = 9'd256;

    // Controller to datapath commands
    typedef struct packed {
        logic take;   // word accepted this cycle
        logic eval;   // resolve the transition from the fetched row
        logic enter;  // apply accept checks of the fetched header
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic over;   // match has ended
        logic dead;   // evaluated target ends the match
    } stat_t;

endpackage

// ===== src/dfarm_ctrl.sv =====
// Sequencing state machine of the DFA matcher.
module dfarm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  dfarm_pkg::func_t     in_func,
    input  logic                 out_ready,
    input  dfarm_pkg::stat_t     stat,
    output logic                 in_ready,
    output logic                 out_valid,
    output dfarm_pkg::cmd_t      cmd
);
    import dfarm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_ENTER = 5'b00100,
        ST_OUT   = 5'b01000,
        ST_SPARE = 5'b10000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        take;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign take      = in_ready & in_valid;

    assign cmd.take  = take;
    assign cmd.eval  = (state_reg == ST_EVAL);
    assign cmd.enter = (state_reg == ST_ENTER);

    // Pick the next step from the accepted function and the datapath status
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (in_func)
                        FUNC_START: state_next = ST_ENTER;
                        FUNC_CHAR:  state_next = stat.over ? ST_OUT : ST_EVAL;
                        default:    state_next = ST_OUT;
                    endcase
                end
            end
            ST_EVAL:  state_next = stat.dead ? ST_OUT : ST_ENTER;
            ST_ENTER: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/dfarm_dp.sv =====
// Table memories, transition compare and match registers of the DFA matcher.
module dfarm_dp #(
    parameter int NUM_STATES  = 256,
    parameter int MAX_RANGES  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dfarm_pkg::cmd_t                   cmd,
    input  dfarm_pkg::func_t                  func,
    input  logic [dfarm_pkg::SIDX_W-1:0]      state_index,
    input  logic [dfarm_pkg::SLOT_W-1:0]      slot,
    input  logic [dfarm_pkg::CHAR_W-1:0]      range_low,
    input  logic [dfarm_pkg::CHAR_W-1:0]      range_high,
    input  logic [dfarm_pkg::TGT_W-1:0]       nxt_state,
    input  logic                              accept_flag,
    input  logic                              nongreedy_flag,
    input  logic [dfarm_pkg::CNT_IN_W-1:0]    range_count,
    input  logic [dfarm_pkg::CHAR_W-1:0]      char_code,
    input  logic                              greedy_mode,
    input  logic [dfarm_pkg::TGT_W-1:0]       dead_state,
    output dfarm_pkg::stat_t                  stat,
    output logic                              matched,
    output logic [dfarm_pkg::OLEN_W-1:0]      match_length,
    output logic                              done_res
);
    import dfarm_pkg::*;

    localparam int SW  = (NUM_STATES > 2) ? $clog2(NUM_STATES) : 1;
    localparam int CW  = $clog2(MAX_RANGES + 1);
    localparam int HW  = 2 + CW + TGT_W;
    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

    // Header layout: accept, nongreedy, count, default target
    logic [HW-1:0]          hdr_mem [NUM_STATES];
    logic [HW-1:0]          hdr_rdata_reg;
    logic [HW-1:0]          hdr_wdata;
    logic [SW-1:0]          hdr_raddr;
    logic                   hdr_rd_en;
    logic                   in_table;
    logic [CW-1:0]          cnt_clamped;

    logic                   hdr_accept;
    logic                   hdr_ng;
    logic [CW-1:0]          hdr_count;
    logic [TGT_W-1:0]       hdr_dflt;

    logic [MAX_RANGES-1:0]  lane_hit;
    logic [TGT_W-1:0]       lane_tgt [MAX_RANGES];
    logic [TGT_W-1:0]       target;

    logic [SW-1:0]          cur_state_reg, cur_state_next;
    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   seen_reg, seen_next;
    logic                   over_reg, over_next;
    logic [CHAR_W-1:0]      char_reg;

    assign in_table    = (32'(state_index) < NUM_STATES);
    assign cnt_clamped = (32'(range_count) > MAX_RANGES) ? CW'(MAX_RANGES) : CW'(range_count);
    assign hdr_wdata   = {accept_flag, nongreedy_flag, cnt_clamped, nxt_state};

    assign {hdr_accept, hdr_ng, hdr_count, hdr_dflt} = hdr_rdata_reg;

    // Header read: state 0 on start, current state on a character, target on eval
    assign hdr_rd_en = (cmd.take & (func == FUNC_START || (func == FUNC_CHAR && !over_reg)))
                     | cmd.eval;
    always_comb
    begin
        if (cmd.eval)
            hdr_raddr = SW'(target);
        else if (func == FUNC_START)
            hdr_raddr = '0;
        else
            hdr_raddr = cur_state_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && func == FUNC_WR_HDR && in_table)
            hdr_mem[SW'(state_index)] <= hdr_wdata;
        if (hdr_rd_en)
            hdr_rdata_reg <= hdr_mem[hdr_raddr];
    end

    // One memory per range slot, so all slots of a row are read together
    for (genvar g = 0; g < MAX_RANGES; g++)
    begin : g_lane
        logic [SLOTE_W-1:0] lane_mem [NUM_STATES];
        logic [SLOTE_W-1:0] rdata_reg;
        logic [CHAR_W-1:0]  lo;
        logic [CHAR_W-1:0]  hi;

        always_ff @(posedge clk)
        begin
            if (cmd.take && func == FUNC_WR_SLOT && in_table && 32'(slot) == g)
                lane_mem[SW'(state_index)] <= {nxt_state, range_high, range_low};
            if (cmd.take && func == FUNC_CHAR && !over_reg)
                rdata_reg <= lane_mem[cur_state_reg];
        end

        assign lo          = rdata_reg[CHAR_W-1:0];
        assign hi          = rdata_reg[2*CHAR_W-1:CHAR_W];
        assign lane_tgt[g] = rdata_reg[SLOTE_W-1:2*CHAR_W];
        assign lane_hit[g] = (g < 32'(hdr_count)) && (lo <= char_reg) && (char_reg <= hi);
    end

    // Take the lowest hitting slot, else the default target
    always_comb
    begin
        target = hdr_dflt;
        for (int i = MAX_RANGES - 1; i >= 0; i--)
        begin
            if (lane_hit[i])
                target = lane_tgt[i];
        end
    end

    assign stat.dead = (target == dead_state) || (32'(target) >= NUM_STATES);
    assign stat.over = over_reg;

    // Match state update
    always_comb
    begin
        cur_state_next = cur_state_reg;
        pos_next       = pos_reg;
        len_next       = len_reg;
        seen_next      = seen_reg;
        over_next      = over_reg;
        if (cmd.take && func == FUNC_START)
        begin
            cur_state_next = '0;
            pos_next       = '0;
            len_next       = '0;
            seen_next      = 1'b0;
            over_next      = 1'b0;
        end
        if (cmd.eval)
        begin
            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 1'b1;
            if (stat.dead)
                over_next = 1'b1;
            else
                cur_state_next = SW'(target);
        end
        if (cmd.enter && hdr_accept)
        begin
            seen_next = 1'b1;
            len_next  = pos_reg;
            if (!greedy_mode && hdr_ng)
                over_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg <= '0;
            pos_reg       <= '0;
            len_reg       <= '0;
            seen_reg      <= 1'b0;
            over_reg      <= 1'b1;
        end
        else
        begin
            cur_state_reg <= cur_state_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            over_reg      <= over_next;
        end
    end

    // Hold the character for the compare
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            char_reg <= char_code;
    end

    assign matched      = seen_reg;
    assign match_length = OLEN_W'(len_reg);
    assign done_res     = over_reg;

endmodule

// ===== src/dfa_range_table_matcher.sv =====
// Top level of the range-table DFA matcher: ports, configuration registers.
//
//  channel   direction  handshake            contents
//  s_*       in         s_tvalid / s_tready  one word: table write, start or character
//  m_*       out        m_tvalid / m_tready  one word: matched, length, done
//  APB       in/out     psel & penable       greedy_mode at 0x0, dead_state at 0x4
//
// A start fetches the header of state 0. A character fetches its row and
// header, compares the slots, fetches the header of the next state and
// applies its accept checks; the checks are skipped when the target ends
// the match, and all steps once the match is done. The result word is held
// until taken, and the next word is accepted in the cycle after that. Reset
// clears the match status to done; table contents are not cleared.
module dfa_range_table_matcher #(
    parameter int NUM_STATES  = 256,
    parameter int MAX_RANGES  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // state_index[7:0], slot[11:8], range_low[32:12], range_high[53:33],
    // nxt_state[62:54], accept_flag[63], nongreedy_flag[64],
    // range_count[69:65], char_code[90:70], zeros[95:91]
    input  logic [95:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // matched[0], match_length[16:1], done_res[17], zeros[23:18]
    output logic [23:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dfarm_pkg::*;

    logic             greedy_reg;
    logic [TGT_W-1:0] dead_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    stat_t            stat;
    func_t            func;
    logic             matched;
    logic [OLEN_W-1:0] match_length;
    logic             done_res;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign func   = func_t'(s_tuser);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            greedy_reg <= 1'b0;
            dead_reg   <= DEAD_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_GREEDY)
                greedy_reg <= pwdata[0];
            if (paddr == ADDR_DEAD)
                dead_reg <= pwdata[TGT_W-1:0];
        end
    end

    // Register read-back
    always_comb
    begin
        case (paddr)
            ADDR_GREEDY: prdata = {31'd0, greedy_reg};
            ADDR_DEAD:   prdata = {23'd0, dead_reg};
            default:     prdata = '0;
        endcase
    end

    dfarm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_func   (func),
        .out_ready (m_tready),
        .stat      (stat),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .cmd       (cmd)
    );

    dfarm_dp #(
        .NUM_STATES  (NUM_STATES),
        .MAX_RANGES  (MAX_RANGES),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .func           (func),
        .state_index    (s_tdata[7:0]),
        .slot           (s_tdata[11:8]),
        .range_low      (s_tdata[32:12]),
        .range_high     (s_tdata[53:33]),
        .nxt_state      (s_tdata[62:54]),
        .accept_flag    (s_tdata[63]),
        .nongreedy_flag (s_tdata[64]),
        .range_count    (s_tdata[69:65]),
        .char_code      (s_tdata[90:70]),
        .greedy_mode    (greedy_reg),
        .dead_state     (dead_reg),
        .stat           (stat),
        .matched        (matched),
        .match_length   (match_length),
        .done_res       (done_res)
    );

    assign m_tdata = {6'd0, done_res, match_length, matched};

endmodule
